// ----- sv/cas_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cas_pkg
// shared constants and types for the complex add/sub/div unit
// ----------------------------------------------------------------------------
package cas_pkg;

    localparam int DATA_WIDTH = 32;
    localparam int FRAC_BITS  = 16;
    localparam int PROD_W     = 2 * DATA_WIDTH;
    localparam int REM_W      = 3 * DATA_WIDTH;
    localparam int OVF_SHIFT  = DATA_WIDTH - FRAC_BITS;

    localparam logic [1:0] CMD_ADD  = 2'd0;
    localparam logic [1:0] CMD_SUB  = 2'd1;
    localparam logic [1:0] CMD_DIV  = 2'd2;
    // unused command, gives a zero result with ok status
    localparam logic [1:0] CMD_NONE = 2'd3;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_DIVZ = 2'd1;
    localparam logic [1:0] ST_OVF  = 2'd2;

    localparam logic signed [DATA_WIDTH-1:0] VAL_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
    localparam logic signed [DATA_WIDTH-1:0] VAL_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};

    // side information that rides along with every item
    typedef struct packed {
        logic                  is_div;
        logic                  dz;
        logic [DATA_WIDTH-1:0] pr;
        logic [DATA_WIDTH-1:0] pi;
        logic [1:0]            pst;
    } side_t;

endpackage

// ----- sv/complex_add_sub_div_unit_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// complex_add_sub_div_unit_top
// pipelined complex add, subtract and divide on signed fixed point operands
// ----------------------------------------------------------------------------
// input to result: stages 1 to 3, precheck, DATA_WIDTH divider stages, output register
// throughput: one item per cycle while the output is not stalled; the restoring divider
//   resolves one quotient bit per stage, so its 32 stages set the depth, not the rate
// a stall at the output freezes the whole pipeline
// reset clears all valid bits; data registers are not reset
module complex_add_sub_div_unit_top
    import cas_pkg::*;
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [1:0]                   cmd,
    input  logic signed [DATA_WIDTH-1:0] a_real,
    input  logic signed [DATA_WIDTH-1:0] a_imag,
    input  logic signed [DATA_WIDTH-1:0] b_real,
    input  logic signed [DATA_WIDTH-1:0] b_imag,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic signed [DATA_WIDTH-1:0] res_real,
    output logic signed [DATA_WIDTH-1:0] res_imag,
    output logic [1:0]                   status
);

    localparam int DW = DATA_WIDTH;

    logic en;

    // stage 1: magnitudes, signs, add/sub
    logic          v1_reg;
    logic [DW-1:0] mar_reg, mai_reg, mbr_reg, mbi_reg;
    logic          sar_reg, sai_reg, sbr_reg, sbi_reg;
    side_t         side1_reg, side1_next;

    // stage 2: products
    logic              v2_reg;
    logic [PROD_W-1:0] p_rr_reg, p_ii_reg, p_ir_reg, p_ri_reg, p_dr_reg, p_di_reg;
    logic              n_rr_reg, n_ii_reg, n_ir_reg, n_ri_reg;
    side_t             side2_reg;

    // stage 3: denominator and numerators
    logic              v3_reg;
    logic [PROD_W-1:0] den3_reg, mr_reg, mi_reg;
    logic              nr3_reg, ni3_reg;
    side_t             side3_reg;
    logic [PROD_W-1:0] mr_next, mi_next;
    logic              nr_next, ni_next;

    // divider pipe, index 0 is the precheck stage
    logic              vd_reg   [0:DW];
    logic [REM_W-1:0]  remr_reg [0:DW];
    logic [REM_W-1:0]  remi_reg [0:DW];
    logic [DW-1:0]     qr_reg   [0:DW];
    logic [DW-1:0]     qi_reg   [0:DW];
    logic [PROD_W-1:0] den_reg  [0:DW];
    logic              nr_reg   [0:DW];
    logic              ni_reg   [0:DW];
    logic              ovr_reg  [0:DW];
    logic              ovi_reg  [0:DW];
    side_t             sided_reg[0:DW];

    // output
    logic                 out_valid_reg;
    logic signed [DW-1:0] res_real_reg, res_imag_reg;
    logic [1:0]           status_reg;
    logic signed [DW-1:0] fr_next, fi_next;
    logic [1:0]           st_next;
    logic                 ofr, ofi;

    assign en       = !out_valid_reg || out_ready;
    assign in_ready = en;

    // ---------------------------------------------------------------- stage 1
    logic signed [DW:0] sum_r, sum_i;
    logic               ovf_r1, ovf_i1;

    always_comb
    begin
        side1_next = '0;
        sum_r = '0;
        sum_i = '0;
        if (cmd == CMD_SUB)
        begin
            sum_r = {a_real[DW-1], a_real} - {b_real[DW-1], b_real};
            sum_i = {a_imag[DW-1], a_imag} - {b_imag[DW-1], b_imag};
        end
        else if (cmd == CMD_ADD)
        begin
            sum_r = {a_real[DW-1], a_real} + {b_real[DW-1], b_real};
            sum_i = {a_imag[DW-1], a_imag} + {b_imag[DW-1], b_imag};
        end
        ovf_r1 = sum_r[DW] != sum_r[DW-1];
        ovf_i1 = sum_i[DW] != sum_i[DW-1];
        side1_next.pr  = ovf_r1 ? (sum_r[DW] ? VAL_MIN : VAL_MAX) : sum_r[DW-1:0];
        side1_next.pi  = ovf_i1 ? (sum_i[DW] ? VAL_MIN : VAL_MAX) : sum_i[DW-1:0];
        side1_next.pst = (ovf_r1 || ovf_i1) ? ST_OVF : ST_OK;
        side1_next.is_div = cmd == CMD_DIV;
        side1_next.dz     = (b_real == '0) && (b_imag == '0);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mar_reg   <= a_real[DW-1] ? -a_real : a_real;
            mai_reg   <= a_imag[DW-1] ? -a_imag : a_imag;
            mbr_reg   <= b_real[DW-1] ? -b_real : b_real;
            mbi_reg   <= b_imag[DW-1] ? -b_imag : b_imag;
            sar_reg   <= a_real[DW-1];
            sai_reg   <= a_imag[DW-1];
            sbr_reg   <= b_real[DW-1];
            sbi_reg   <= b_imag[DW-1];
            side1_reg <= side1_next;
        end
    end

    // ---------------------------------------------------------------- stage 2
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_rr_reg  <= PROD_W'(mar_reg) * PROD_W'(mbr_reg);
            p_ii_reg  <= PROD_W'(mai_reg) * PROD_W'(mbi_reg);
            p_ir_reg  <= PROD_W'(mai_reg) * PROD_W'(mbr_reg);
            p_ri_reg  <= PROD_W'(mar_reg) * PROD_W'(mbi_reg);
            p_dr_reg  <= PROD_W'(mbr_reg) * PROD_W'(mbr_reg);
            p_di_reg  <= PROD_W'(mbi_reg) * PROD_W'(mbi_reg);
            n_rr_reg  <= sar_reg != sbr_reg;
            n_ii_reg  <= sai_reg != sbi_reg;
            n_ir_reg  <= sai_reg != sbr_reg;
            // imaginary numerator subtracts a_real*b_imag
            n_ri_reg  <= !(sar_reg != sbi_reg);
            side2_reg <= side1_reg;
        end
    end

    // ---------------------------------------------------------------- stage 3
    always_comb
    begin
        if (n_rr_reg == n_ii_reg)
        begin
            mr_next = p_rr_reg + p_ii_reg;
            nr_next = n_rr_reg;
        end
        else if (p_rr_reg >= p_ii_reg)
        begin
            mr_next = p_rr_reg - p_ii_reg;
            nr_next = n_rr_reg;
        end
        else
        begin
            mr_next = p_ii_reg - p_rr_reg;
            nr_next = n_ii_reg;
        end
        if (n_ir_reg == n_ri_reg)
        begin
            mi_next = p_ir_reg + p_ri_reg;
            ni_next = n_ir_reg;
        end
        else if (p_ir_reg >= p_ri_reg)
        begin
            mi_next = p_ir_reg - p_ri_reg;
            ni_next = n_ir_reg;
        end
        else
        begin
            mi_next = p_ri_reg - p_ir_reg;
            ni_next = n_ri_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            den3_reg  <= p_dr_reg + p_di_reg;
            mr_reg    <= mr_next;
            mi_reg    <= mi_next;
            nr3_reg   <= nr_next;
            ni3_reg   <= ni_next;
            side3_reg <= side2_reg;
        end
    end

    // ------------------------------------------------------ stage 4: precheck
    // quotient reaches 2^DW exactly when num >= den << (DW - FRAC_BITS)
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            remr_reg[0]  <= REM_W'(mr_reg) << FRAC_BITS;
            remi_reg[0]  <= REM_W'(mi_reg) << FRAC_BITS;
            ovr_reg[0]   <= REM_W'(mr_reg) >= (REM_W'(den3_reg) << OVF_SHIFT);
            ovi_reg[0]   <= REM_W'(mi_reg) >= (REM_W'(den3_reg) << OVF_SHIFT);
            qr_reg[0]    <= '0;
            qi_reg[0]    <= '0;
            den_reg[0]   <= den3_reg;
            nr_reg[0]    <= nr3_reg && (mr_reg != '0);
            ni_reg[0]    <= ni3_reg && (mi_reg != '0);
            sided_reg[0] <= side3_reg;
        end
    end

    // ------------------------------------- restoring divider, one bit a stage
    for (genvar k = 0; k < DW; k++)
    begin : g_div
        localparam int BIT = DW - 1 - k;
        logic [REM_W-1:0] dsh;
        assign dsh = REM_W'(den_reg[k]) << BIT;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (remr_reg[k] >= dsh)
                begin
                    remr_reg[k+1] <= remr_reg[k] - dsh;
                    qr_reg[k+1]   <= qr_reg[k] | (DW'(1) << BIT);
                end
                else
                begin
                    remr_reg[k+1] <= remr_reg[k];
                    qr_reg[k+1]   <= qr_reg[k];
                end
                if (remi_reg[k] >= dsh)
                begin
                    remi_reg[k+1] <= remi_reg[k] - dsh;
                    qi_reg[k+1]   <= qi_reg[k] | (DW'(1) << BIT);
                end
                else
                begin
                    remi_reg[k+1] <= remi_reg[k];
                    qi_reg[k+1]   <= qi_reg[k];
                end
                den_reg[k+1]   <= den_reg[k];
                nr_reg[k+1]    <= nr_reg[k];
                ni_reg[k+1]    <= ni_reg[k];
                ovr_reg[k+1]   <= ovr_reg[k];
                ovi_reg[k+1]   <= ovi_reg[k];
                sided_reg[k+1] <= sided_reg[k];
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vd_reg[k+1] <= 1'b0;
            else if (en)
                vd_reg[k+1] <= vd_reg[k];
        end
    end

    // ----------------------------------------------- sign, saturation, status
    always_comb
    begin
        logic [DW-1:0] qr, qi;
        qr = qr_reg[DW];
        qi = qi_reg[DW];
        if (nr_reg[DW])
            ofr = ovr_reg[DW] || (qr > (DW'(1) << (DW - 1)));
        else
            ofr = ovr_reg[DW] || (qr > DW'(VAL_MAX));
        if (ni_reg[DW])
            ofi = ovi_reg[DW] || (qi > (DW'(1) << (DW - 1)));
        else
            ofi = ovi_reg[DW] || (qi > DW'(VAL_MAX));

        if (!sided_reg[DW].is_div)
        begin
            fr_next = sided_reg[DW].pr;
            fi_next = sided_reg[DW].pi;
            st_next = sided_reg[DW].pst;
        end
        else if (sided_reg[DW].dz)
        begin
            fr_next = '0;
            fi_next = '0;
            st_next = ST_DIVZ;
        end
        else
        begin
            if (ofr)
                fr_next = nr_reg[DW] ? VAL_MIN : VAL_MAX;
            else
                fr_next = nr_reg[DW] ? -qr : qr;
            if (ofi)
                fi_next = ni_reg[DW] ? VAL_MIN : VAL_MAX;
            else
                fi_next = ni_reg[DW] ? -qi : qi;
            st_next = (ofr || ofi) ? ST_OVF : ST_OK;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            res_real_reg <= fr_next;
            res_imag_reg <= fi_next;
            status_reg   <= st_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            vd_reg[0]     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg        <= in_valid;
            v2_reg        <= v1_reg;
            v3_reg        <= v2_reg;
            vd_reg[0]     <= v3_reg;
            out_valid_reg <= vd_reg[DW];
        end
    end

    assign out_valid = out_valid_reg;
    assign res_real  = res_real_reg;
    assign res_imag  = res_imag_reg;
    assign status    = status_reg;

endmodule

// ----- sv/cas_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cas_checker
// port-level checks for the complex add/sub/div unit
// ----------------------------------------------------------------------------
module cas_checker
    import cas_pkg::*;
(
    input logic                         clk,
    input logic                         rst_n,
    input logic                         in_ready,
    input logic                         out_valid,
    input logic                         out_ready,
    input logic signed [DATA_WIDTH-1:0] res_real,
    input logic signed [DATA_WIDTH-1:0] res_imag,
    input logic [1:0]                   status
);

    // a waiting result holds until its transfer
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(res_real) && $stable(res_imag)
            && $stable(status))
        else $error("result changed while stalled");

    // input backs off only when the output is blocked
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid && !out_ready)
        else $error("input stalled without output backpressure");

    // divide by zero gives a zero result
    a_divz: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == ST_DIVZ |-> res_real == '0 && res_imag == '0)
        else $error("divide by zero with nonzero result");

    // overflow leaves at least one part at a bound
    a_ovf: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == ST_OVF |->
            res_real == VAL_MAX || res_real == VAL_MIN
            || res_imag == VAL_MAX || res_imag == VAL_MIN)
        else $error("overflow status without saturated part");

    a_status: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> status == ST_OK || status == ST_DIVZ || status == ST_OVF)
        else $error("unused status code");

endmodule

bind complex_add_sub_div_unit_top cas_checker u_cas_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .res_real  (res_real),
    .res_imag  (res_imag),
    .status    (status)
);

// ----- test/tb_complex_add_sub_div_unit_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_complex_add_sub_div_unit_top
// self-checking bench: queued operand sets, random gaps and backpressure,
// results checked against an in-bench fixed point model
// ----------------------------------------------------------------------------
module tb_complex_add_sub_div_unit_top
    import cas_pkg::*;
;

    typedef struct packed {
        logic [1:0]                   op;
        logic signed [DATA_WIDTH-1:0] ar;
        logic signed [DATA_WIDTH-1:0] ai;
        logic signed [DATA_WIDTH-1:0] br;
        logic signed [DATA_WIDTH-1:0] bi;
    } operands_t;

    typedef struct packed {
        logic signed [DATA_WIDTH-1:0] re;
        logic signed [DATA_WIDTH-1:0] im;
        logic [1:0]                   st;
    } cresult_t;

    localparam int TIMEOUT_CYCLES = 200000;
    localparam int DRAIN_CYCLES   = 60;

    logic                         clk = 1'b0;
    logic                         rst_n = 1'b0;
    logic                         in_valid = 1'b0;
    logic                         in_ready;
    logic [1:0]                   cmd = CMD_ADD;
    logic signed [DATA_WIDTH-1:0] a_real = '0;
    logic signed [DATA_WIDTH-1:0] a_imag = '0;
    logic signed [DATA_WIDTH-1:0] b_real = '0;
    logic signed [DATA_WIDTH-1:0] b_imag = '0;
    logic                         out_valid;
    logic                         out_ready = 1'b0;
    logic signed [DATA_WIDTH-1:0] res_real;
    logic signed [DATA_WIDTH-1:0] res_imag;
    logic [1:0]                   status;

    operands_t pending_ops[$];
    cresult_t  expected_results[$];
    int        mismatches = 0;
    int        sent = 0;
    int        received = 0;
    int        cycle = 0;

    complex_add_sub_div_unit_top u_dut (.*);

    always #5 clk = ~clk;

    // clamp a wide signed value into the data range
    function automatic logic signed [DATA_WIDTH-1:0] clamp(
        input logic signed [127:0] v, inout logic ovf);
        if (v > 128'(signed'(VAL_MAX)))
        begin
            ovf = 1'b1;
            return VAL_MAX;
        end
        if (v < 128'(signed'(VAL_MIN)))
        begin
            ovf = 1'b1;
            return VAL_MIN;
        end
        return v[DATA_WIDTH-1:0];
    endfunction

    // quotient scaled by 2^FRAC_BITS, truncated toward zero
    function automatic logic signed [127:0] scaled_quot(
        input logic signed [127:0] num, input logic [127:0] den);
        logic [127:0] m;
        logic [127:0] q;
        m = num < 0 ? 128'(-num) : 128'(num);
        q = (m << FRAC_BITS) / den;
        return num < 0 ? -$signed(q) : $signed(q);
    endfunction

    function automatic cresult_t complex_result(input operands_t x);
        cresult_t r;
        logic ovf;
        logic signed [127:0] ar, ai, br, bi;
        logic [127:0] den;
        ovf = 1'b0;
        r = '0;
        ar = 128'(x.ar);
        ai = 128'(x.ai);
        br = 128'(x.br);
        bi = 128'(x.bi);
        case (x.op)
            CMD_ADD:
            begin
                r.re = clamp(ar + br, ovf);
                r.im = clamp(ai + bi, ovf);
            end
            CMD_SUB:
            begin
                r.re = clamp(ar - br, ovf);
                r.im = clamp(ai - bi, ovf);
            end
            CMD_DIV:
            begin
                if (br == 0 && bi == 0)
                begin
                    r.st = ST_DIVZ;
                end
                else
                begin
                    den = br * br + bi * bi;
                    r.re = clamp(scaled_quot(ar * br + ai * bi, den), ovf);
                    r.im = clamp(scaled_quot(ai * br - ar * bi, den), ovf);
                end
            end
            default: ;
        endcase
        if (ovf)
            r.st = ST_OVF;
        return r;
    endfunction

    function automatic logic signed [DATA_WIDTH-1:0] rand_part();
        case ($urandom_range(0, 5))
            0: return VAL_MAX - $urandom_range(0, 3);
            1: return VAL_MIN + $urandom_range(0, 3);
            2: return $signed(32'($urandom_range(0, 8 << FRAC_BITS))) - (4 << FRAC_BITS);
            3: return '0;
            default: return $urandom;
        endcase
    endfunction

    function automatic operands_t mk(input logic [1:0] op,
        input logic signed [DATA_WIDTH-1:0] ar, input logic signed [DATA_WIDTH-1:0] ai,
        input logic signed [DATA_WIDTH-1:0] br, input logic signed [DATA_WIDTH-1:0] bi);
        operands_t x;
        x.op = op;
        x.ar = ar;
        x.ai = ai;
        x.br = br;
        x.bi = bi;
        return x;
    endfunction

    // quiet window: no gaps and no backpressure
    function automatic bit quiet(input int n);
        return n >= 300 && n < 450;
    endfunction

    always @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            expected_results.push_back(complex_result({cmd, a_real, a_imag, b_real, b_imag}));
            sent <= sent + 1;
        end
        if (rst_n && (!in_valid || in_ready))
        begin
            if (pending_ops.size() > 0 && (quiet(sent) || $urandom_range(0, 99) >= 19))
            begin
                operands_t x;
                x = pending_ops.pop_front();
                in_valid <= 1'b1;
                cmd      <= x.op;
                a_real   <= x.ar;
                a_imag   <= x.ai;
                b_real   <= x.br;
                b_imag   <= x.bi;
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        if (out_valid && out_ready)
        begin
            received <= received + 1;
            if (expected_results.size() == 0)
            begin
                mismatches <= mismatches + 1;
                if (mismatches < 10)
                    $display("unexpected transfer: re=%0d im=%0d st=%0d",
                             res_real, res_imag, status);
            end
            else
            begin
                cresult_t e;
                e = expected_results.pop_front();
                if (e.re !== res_real || e.im !== res_imag || e.st !== status)
                begin
                    mismatches <= mismatches + 1;
                    if (mismatches < 10)
                        $display({"mismatch %0d: exp re=%0d im=%0d st=%0d",
                                  " got re=%0d im=%0d st=%0d"},
                                 received, e.re, e.im, e.st, res_real, res_imag, status);
                end
            end
        end
        if (rst_n)
            out_ready <= quiet(received) || $urandom_range(0, 99) >= 19;
    end

    always @(posedge clk)
    begin
        cycle <= cycle + 1;
        if (cycle >= TIMEOUT_CYCLES)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial
    begin
        logic signed [DATA_WIDTH-1:0] one;
        one = 1 << FRAC_BITS;
        pending_ops.push_back(mk(CMD_ADD, VAL_MAX, VAL_MIN, VAL_MAX, VAL_MIN));
        pending_ops.push_back(mk(CMD_ADD, VAL_MAX, VAL_MIN, VAL_MIN, VAL_MAX));
        pending_ops.push_back(mk(CMD_ADD, one, -one, 3, -5));
        pending_ops.push_back(mk(CMD_SUB, VAL_MIN, VAL_MAX, 1, -1));
        pending_ops.push_back(mk(CMD_SUB, VAL_MAX, VAL_MIN, VAL_MAX, VAL_MIN));
        pending_ops.push_back(mk(CMD_SUB, 0, 0, VAL_MIN, VAL_MIN));
        pending_ops.push_back(mk(CMD_DIV, one, one, 0, 0));
        pending_ops.push_back(mk(CMD_DIV, 0, 0, 0, 0));
        pending_ops.push_back(mk(CMD_DIV, one, 0, 0, one));
        pending_ops.push_back(mk(CMD_DIV, 3 * one, -2 * one, one, one));
        pending_ops.push_back(mk(CMD_DIV, VAL_MAX, VAL_MAX, 1, 0));
        pending_ops.push_back(mk(CMD_DIV, VAL_MIN, VAL_MIN, -1, 0));
        pending_ops.push_back(mk(CMD_DIV, VAL_MIN, VAL_MAX, VAL_MIN, VAL_MIN));
        pending_ops.push_back(mk(CMD_DIV, 1, -1, VAL_MAX, VAL_MIN));
        pending_ops.push_back(mk(CMD_DIV, -7, 5, 0, -3));
        pending_ops.push_back(mk(CMD_NONE, VAL_MAX, VAL_MIN, -1, 1));
        pending_ops.push_back(mk(CMD_NONE, 0, 0, 0, 0));
        repeat (800)
        begin
            logic [1:0] op;
            op = $urandom_range(0, 19) == 0 ? CMD_NONE : 2'($urandom_range(0, 2));
            pending_ops.push_back(mk(op, rand_part(), rand_part(), rand_part(), rand_part()));
        end
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        wait (pending_ops.size() == 0 && !in_valid && expected_results.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0 && expected_results.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// ----- files.f -----
sv/cas_pkg.sv
sv/complex_add_sub_div_unit_top.sv
sv/cas_checker.sv
test/tb_complex_add_sub_div_unit_top.sv
